FILE: rtl/cstok_pkg.sv
// ----------------------------------------------------------------------------
// cstok_pkg
// Shared types, token codes and character classes for the C subset tokenizer.
// ----------------------------------------------------------------------------
package cstok_pkg;

  localparam logic [2:0] KIND_PUNCT   = 3'd0;
  localparam logic [2:0] KIND_INT     = 3'd1;
  localparam logic [2:0] KIND_KW_INT  = 3'd2;
  localparam logic [2:0] KIND_KW_RET  = 3'd3;
  localparam logic [2:0] KIND_IDENT   = 3'd4;
  localparam logic [2:0] KIND_UNKNOWN = 3'd5;

  localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FLUSH = 4'b0010,
    S_WORD  = 4'b0100,
    S_TAIL  = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic emit_flush;
    logic rd_start;
    logic emit_char;
    logic rd_next;
    logic emit_tail;
    logic start;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cont;
    logic mode_idle;
    logic word_ident;
    logic tail;
    logic replay_last;
    logic out_free;
  } status_t;

  function automatic logic is_num_char(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c == 8'h5F) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h7B, 8'h7D, 8'h28, 8'h29, 8'h3B, 8'h2D,
      8'h7E, 8'h21, 8'h2B, 8'h2A, 8'h2F: r = 1'b1;
      default:                           r = 1'b0;
    endcase
    return r;
  endfunction

  // "int"
  function automatic logic [7:0] kw_int_at(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h69;
      3'd1:    r = 8'h6E;
      3'd2:    r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "return"
  function automatic logic [7:0] kw_ret_at(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h72;
      3'd1:    r = 8'h65;
      3'd2:    r = 8'h74;
      3'd3:    r = 8'h75;
      3'd4:    r = 8'h72;
      3'd5:    r = 8'h6E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/cstok_ram.sv
// ----------------------------------------------------------------------------
// cstok_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cstok_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cstok_ctrl.sv
// ----------------------------------------------------------------------------
// cstok_ctrl
// Sequencer: takes a byte, then walks flush, identifier replay and the
// trailing token of the byte that ended the previous token.
// ----------------------------------------------------------------------------
module cstok_ctrl
  import cstok_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!sts.cont) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (sts.mode_idle) begin
          // nothing pending, go straight to the trailing token
          if (!sts.tail) begin
            cmd.start  = 1'b1;
            state_next = S_IDLE;
          end else if (sts.out_free) begin
            cmd.emit_tail = 1'b1;
            cmd.start     = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (sts.word_ident) begin
          cmd.rd_start = 1'b1;
          state_next   = S_WORD;
        end else if (sts.out_free) begin
          cmd.emit_flush = 1'b1;
          state_next     = S_TAIL;
        end
      end
      S_WORD: begin
        if (sts.out_free) begin
          cmd.emit_char = 1'b1;
          if (sts.replay_last) begin
            state_next = S_TAIL;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      S_TAIL: begin
        if (!sts.tail) begin
          cmd.start  = 1'b1;
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_tail = 1'b1;
          cmd.start     = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_end_goes_flush: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !sts.cont) |=> (state == S_FLUSH))
    else $error("token end did not enter flush");

  a_read_goes_word: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_start |=> (state == S_WORD))
    else $error("replay read without replay state");

  a_start_goes_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_IDLE))
    else $error("token start did not return to idle");

endmodule

FILE: rtl/cstok_dp.sv
// ----------------------------------------------------------------------------
// cstok_dp
// Datapath: literal accumulator, word buffer with keyword tracking, held
// terminating byte and the result register.
// ----------------------------------------------------------------------------
module cstok_dp
  import cstok_pkg::*;
#(
  parameter int MAX_IDENT_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     sts,
  input  logic [7:0]  char_in,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [7:0]  token_char,
  output logic [30:0] int_value,
  output logic        value_overflow,
  output logic        text_truncated,
  output logic        text_end,
  output logic        last
);

  localparam int LEN_W  = $clog2(MAX_IDENT_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_IDENT_LEN);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_IDENT_LEN);

  mode_t             mode;
  logic [30:0]       accum;
  logic              ovf;
  logic [LEN_W-1:0]  len;
  logic              trunc;
  logic              kw_int_ok;
  logic              kw_ret_ok;
  logic [7:0]        c_hold;
  logic              eos_hold;
  logic [LEN_W-1:0]  rd_idx;

  logic              cont;
  logic              room;
  logic [34:0]       accum_wide;
  logic              accum_sat;
  logic              kw_int_match;
  logic              kw_ret_match;
  logic              hold_digit;
  logic              hold_alpha;
  logic              tail;
  logic [LEN_W-1:0]  rd_idx_inc;
  logic              replay_last;
  logic              out_free;
  logic              emit;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign cont = !end_of_stream &&
                (((mode == MODE_NUM) && is_num_char(char_in)) ||
                 ((mode == MODE_WORD) && (is_alpha(char_in) || is_num_char(char_in))));
  assign room = (len < MAX_LEN);

  // accum * 10 + digit as two shifts and two adds
  assign accum_wide = ({4'd0, accum} << 3) + ({4'd0, accum} << 1) +
                      {31'd0, char_in[3:0]};
  assign accum_sat  = (accum_wide > {4'd0, INT_SAT});

  assign kw_int_match = !trunc && kw_int_ok && (len == LEN_W'(3));
  assign kw_ret_match = !trunc && kw_ret_ok && (len == LEN_W'(6));

  assign hold_digit = !eos_hold && is_num_char(c_hold);
  assign hold_alpha = !eos_hold && is_alpha(c_hold);
  assign tail       = !eos_hold && !is_space(c_hold) && !is_num_char(c_hold) &&
                      !is_alpha(c_hold);

  assign rd_idx_inc  = rd_idx + LEN_W'(1);
  assign replay_last = (rd_idx_inc == len);
  assign out_free    = !out_valid || !out_stall;
  assign emit        = cmd.emit_flush || cmd.emit_char || cmd.emit_tail;

  assign sts.cont        = cont;
  assign sts.mode_idle   = (mode == MODE_IDLE);
  assign sts.word_ident  = (mode == MODE_WORD) && !kw_int_match && !kw_ret_match;
  assign sts.tail        = tail;
  assign sts.replay_last = replay_last;
  assign sts.out_free    = out_free;

  // a new word writes entry zero only after the old word has been replayed
  assign ram_we    = (cmd.accept && cont && (mode == MODE_WORD) && room) ||
                     (cmd.start && hold_alpha);
  assign ram_waddr = cmd.start ? '0 : len[ADDR_W-1:0];
  assign ram_wdata = cmd.start ? c_hold : char_in;
  assign ram_re    = cmd.rd_start || cmd.rd_next;
  assign ram_raddr = cmd.rd_start ? '0 : rd_idx_inc[ADDR_W-1:0];

  cstok_ram #(
    .WIDTH (8),
    .DEPTH (MAX_IDENT_LEN)
  ) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      accum     <= '0;
      ovf       <= 1'b0;
      len       <= '0;
      trunc     <= 1'b0;
      kw_int_ok <= 1'b0;
      kw_ret_ok <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept && cont) begin
        if (mode == MODE_NUM) begin
          accum <= accum_sat ? INT_SAT : accum_wide[30:0];
          if (accum_sat) begin
            ovf <= 1'b1;
          end
        end else if (room) begin
          len       <= len + LEN_W'(1);
          kw_int_ok <= kw_int_ok && (len < LEN_W'(3)) &&
                       (char_in == kw_int_at(len[2:0]));
          kw_ret_ok <= kw_ret_ok && (len < LEN_W'(6)) &&
                       (char_in == kw_ret_at(len[2:0]));
        end else begin
          trunc <= 1'b1;
        end
      end
      if (cmd.start) begin
        mode      <= hold_digit ? MODE_NUM : (hold_alpha ? MODE_WORD : MODE_IDLE);
        accum     <= hold_digit ? {27'd0, c_hold[3:0]} : '0;
        ovf       <= 1'b0;
        len       <= hold_alpha ? LEN_W'(1) : '0;
        trunc     <= 1'b0;
        kw_int_ok <= (c_hold == kw_int_at(3'd0));
        kw_ret_ok <= (c_hold == kw_ret_at(3'd0));
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && !cont) begin
      c_hold   <= char_in;
      eos_hold <= end_of_stream;
    end
    if (cmd.rd_start) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= rd_idx_inc;
    end
    if (cmd.emit_flush) begin
      token_kind     <= (mode == MODE_NUM) ? KIND_INT :
                        (kw_int_match ? KIND_KW_INT : KIND_KW_RET);
      token_char     <= '0;
      int_value      <= (mode == MODE_NUM) ? accum : '0;
      value_overflow <= (mode == MODE_NUM) && ovf;
      text_truncated <= 1'b0;
      text_end       <= 1'b0;
      last           <= !tail;
    end else if (cmd.emit_char) begin
      token_kind     <= KIND_IDENT;
      token_char     <= ram_rdata;
      int_value      <= '0;
      value_overflow <= 1'b0;
      text_truncated <= trunc;
      text_end       <= replay_last;
      last           <= replay_last && !tail;
    end else if (cmd.emit_tail) begin
      token_kind     <= is_punct(c_hold) ? KIND_PUNCT : KIND_UNKNOWN;
      token_char     <= c_hold;
      int_value      <= '0;
      value_overflow <= 1'b0;
      text_truncated <= 1'b0;
      text_end       <= 1'b0;
      last           <= 1'b1;
    end
  end

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result written over an untaken result");

  a_single_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_flush, cmd.emit_char, cmd.emit_tail}))
    else $error("more than one result source in a cycle");

  a_word_nonempty: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_WORD) |-> (len != '0))
    else $error("word mode with empty buffer");

endmodule

FILE: rtl/c_subset_tokenizer.sv
// ----------------------------------------------------------------------------
// c_subset_tokenizer
// Byte-serial lexer for a small C subset: punctuation, saturating integer
// literals, the keywords int and return, and identifiers sent as text.
//
//   channel   dir   handshake           payload
//   in        in    in_valid/in_stall   char_in, end_of_stream
//   out       out   out_valid/out_stall token_kind, token_char, int_value,
//                                       value_overflow, text_truncated,
//                                       text_end, last
//
// a byte that continues a literal or word is taken while the sequencer stays idle
// a byte that ends a token stalls the input while the sequencer walks the
// flush of a literal or keyword, the replay of an identifier's stored characters
// from the word buffer RAM, one entry per cycle while the output is free, and
// the trailing token; out_stall holds the sequencer wherever it has a result to write
// rst is synchronous; no clearing pass, the word buffer is read only below
// its current length
// ----------------------------------------------------------------------------
module c_subset_tokenizer
  import cstok_pkg::*;
#(
  parameter int MAX_IDENT_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [7:0]  token_char,
  output logic [30:0] int_value,
  output logic        value_overflow,
  output logic        text_truncated,
  output logic        text_end,
  output logic        last
);

  cmd_t    cmd;
  status_t sts;

  cstok_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cstok_dp #(
    .MAX_IDENT_LEN (MAX_IDENT_LEN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .char_in        (char_in),
    .end_of_stream  (end_of_stream),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .token_kind     (token_kind),
    .token_char     (token_char),
    .int_value      (int_value),
    .value_overflow (value_overflow),
    .text_truncated (text_truncated),
    .text_end       (text_end),
    .last           (last)
  );

endmodule
